### rtl/hlrc_pkg.sv
// shared constants, types and helpers for the host link response checker
package hlrc_pkg;

    localparam int MAX_REGISTERS = 256;
    localparam int MAX_BATCH     = 32;
    localparam int BATCH_CAP     = (MAX_BATCH < 30) ? MAX_BATCH : 30;
    localparam int WADDR_W       = $clog2(MAX_BATCH);

    localparam logic [4:0] BATCH_LIMIT   = 5'd30;
    localparam logic [4:0] BATCH_DEFAULT = 5'd25;

    // register indexes
    localparam logic [1:0] REG_SECTION = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_BATCH   = 2'd2;

    // section kinds
    localparam logic [1:0] SEC_DM = 2'd0;
    localparam logic [1:0] SEC_HR = 2'd1;
    localparam logic [1:0] SEC_IO = 2'd2;

    // frame status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NO_AT    = 4'd1;
    localparam logic [3:0] ST_END_CODE = 4'd2;
    localparam logic [3:0] ST_LENGTH   = 4'd3;
    localparam logic [3:0] ST_NO_CR    = 4'd4;
    localparam logic [3:0] ST_NO_STAR  = 4'd5;
    localparam logic [3:0] ST_COMMAND  = 4'd6;
    localparam logic [3:0] ST_FCS      = 4'd7;
    localparam logic [3:0] ST_NO_RESP  = 4'd8;

    // frame characters
    localparam logic [7:0]  CH_AT     = 8'h40;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_R      = 8'h52;
    localparam logic [15:0] END_OK    = 16'h3030;
    localparam logic [7:0]  FRAME_OVH = 8'd11;

    typedef struct packed {
        logic [1:0] section_kind;
        logic [8:0] register_count;
        logic [4:0] batch_count;
    } cfg_t;

    typedef struct packed {
        logic        done;
        logic [3:0]  status;
        logic [15:0] end_code;
    } verdict_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [31:0]        data;
    } word_wr_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    function automatic logic [7:0] echo_second(input logic [1:0] kind);
        logic [7:0] c;
        case (kind)
            SEC_DM:  c = 8'h44;
            SEC_HR:  c = 8'h48;
            SEC_IO:  c = 8'h52;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/hlrc_cfg.sv
// apb configuration registers
module hlrc_cfg
    import hlrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0] section_kind_reg, section_kind_next;
    logic [8:0] register_count_reg, register_count_next;
    logic [4:0] batch_count_reg, batch_count_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        section_kind_next   = section_kind_reg;
        register_count_next = register_count_reg;
        batch_count_next    = batch_count_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_SECTION: section_kind_next = pwdata[1:0];
                REG_COUNT:
                begin
                    register_count_next = (pwdata[8:0] > 9'(MAX_REGISTERS)) ?
                                          9'(MAX_REGISTERS) : pwdata[8:0];
                end
                REG_BATCH:
                begin
                    batch_count_next = (pwdata[4:0] > BATCH_LIMIT) ?
                                       BATCH_DEFAULT : pwdata[4:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_kind_reg   <= SEC_DM;
            register_count_reg <= 9'd0;
            batch_count_reg    <= BATCH_DEFAULT;
        end
        else
        begin
            section_kind_reg   <= section_kind_next;
            register_count_reg <= register_count_next;
            batch_count_reg    <= batch_count_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SECTION: prdata = {30'd0, section_kind_reg};
            REG_COUNT:   prdata = {23'd0, register_count_reg};
            REG_BATCH:   prdata = {27'd0, batch_count_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.section_kind   = section_kind_reg;
    assign cfg.register_count = register_count_reg;
    assign cfg.batch_count    = batch_count_reg;

endmodule

### rtl/hlrc_word_ram.sv
// staged word memory, one write port and one registered read port
module hlrc_word_ram
    import hlrc_pkg::*;
(
    input  logic               clk,
    input  word_wr_t           wr,
    input  logic               rd_en,
    input  logic [WADDR_W-1:0] rd_addr,
    output logic [31:0]        rd_data
);

    logic [31:0] mem [MAX_BATCH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/hlrc_frame_check.sv
// per-byte frame tracking, word staging writes and final status
module hlrc_frame_check
    import hlrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       abort,
    input  logic [7:0] rx_byte,
    input  logic       frame_last,
    input  logic [1:0] section_kind,
    input  logic [4:0] words_exp,
    output logic       first_byte,
    output verdict_t   verdict,
    output word_wr_t   word_wr
);

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] recent_reg, recent_next;
    logic        ferr_reg, ferr_next;
    logic [31:0] echo_reg, echo_next;

    logic [7:0]  pos_new, xor_new, fcs, pm7, frame_len;
    logic [31:0] recent_new, echo_new;
    logic        ferr_new;
    logic [3:0]  st;

    assign first_byte = (pos_reg == 8'd0);

    always_comb
    begin
        pos_new    = (pos_reg == 8'd255) ? pos_reg : pos_reg + 8'd1;
        xor_new    = xor_reg ^ rx_byte;
        recent_new = {recent_reg[23:0], rx_byte};
        ferr_new   = ferr_reg | (first_byte && (rx_byte != CH_AT));
        echo_new   = echo_reg;
        case (pos_reg)
            8'd3:    echo_new[31:24] = echo_reg[31:24] | rx_byte;
            8'd4:    echo_new[23:16] = echo_reg[23:16] | rx_byte;
            8'd5:    echo_new[15:8]  = echo_reg[15:8]  | rx_byte;
            8'd6:    echo_new[7:0]   = echo_reg[7:0]   | rx_byte;
            default: ;
        endcase
    end

    // a word is complete on its fourth character
    assign pm7          = pos_reg - 8'd7;
    assign word_wr.en   = byte_valid && (pos_reg >= 8'd7) && (pm7[1:0] == 2'd3)
                          && ({2'd0, pm7[7:2]} < 8'(MAX_BATCH));
    assign word_wr.addr = pm7[WADDR_W+1:2];
    assign word_wr.data = recent_new;

    assign fcs       = xor_new ^ recent_new[31:24] ^ recent_new[23:16]
                       ^ recent_new[15:8] ^ recent_new[7:0];
    assign frame_len = {1'b0, words_exp, 2'b00} + FRAME_OVH;

    always_comb
    begin
        if (ferr_new)
            st = ST_NO_AT;
        else if (echo_new[15:0] != END_OK)
            st = ST_END_CODE;
        else if (pos_new != frame_len)
            st = ST_LENGTH;
        else if (recent_new[7:0] != CH_CR)
            st = ST_NO_CR;
        else if (recent_new[15:8] != CH_STAR)
            st = ST_NO_STAR;
        else if ((section_kind > SEC_IO) || (echo_new[31:24] != CH_R)
                 || (echo_new[23:16] != echo_second(section_kind)))
            st = ST_COMMAND;
        else if ((recent_new[31:24] != hex_char(fcs[7:4]))
                 || (recent_new[23:16] != hex_char(fcs[3:0])))
            st = ST_FCS;
        else
            st = ST_OK;
    end

    assign verdict.done     = byte_valid & frame_last;
    assign verdict.status   = st;
    assign verdict.end_code = echo_new[15:0];

    always_comb
    begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        recent_next = recent_reg;
        ferr_next   = ferr_reg;
        echo_next   = echo_reg;
        if (abort || (byte_valid && frame_last))
        begin
            pos_next    = 8'd0;
            xor_next    = 8'd0;
            recent_next = 32'd0;
            ferr_next   = 1'b0;
            echo_next   = 32'd0;
        end
        else if (byte_valid)
        begin
            pos_next    = pos_new;
            xor_next    = xor_new;
            recent_next = recent_new;
            ferr_next   = ferr_new;
            echo_next   = echo_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            xor_reg    <= 8'd0;
            recent_reg <= 32'd0;
            ferr_reg   <= 1'b0;
            echo_reg   <= 32'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            recent_reg <= recent_next;
            ferr_reg   <= ferr_next;
            echo_reg   <= echo_next;
        end
    end

endmodule

### rtl/host_link_response_checker.sv
// host link read-response checker top level
// Frame bytes and no-response events are taken one per cycle while the block is idle and
// the output register is free or being drained. A bad frame or a missing response gives
// one status transfer in the cycle after it is taken. A good frame gives one data
// transfer per polled register; each word is fetched through the single registered read
// port of the staged word memory, and input is held off until the last word is loaded.
// Words are staged there as their fourth character arrives; from the third straight failure
// on, a status transfer also carries the register range whose valid marks to clear.
module host_link_response_checker
    import hlrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [0:0]  s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // register_index[7:0], word_chars[39:8], status[43:40], end_code[59:44],
    // invalidate[60], invalidate_start[68:61], invalidate_count[73:69], zero[79:74]
    output logic [79:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EMIT_RD = 2'd1;
    localparam logic [1:0] S_EMIT_LD = 2'd2;

    cfg_t     cfg;
    verdict_t verdict;
    word_wr_t word_wr;

    logic [1:0] state_reg, state_next;
    logic [7:0] ws_reg, ws_next;
    logic [4:0] wexp_reg, wexp_next;
    logic [1:0] fail_reg, fail_next;
    logic [7:0] ebase_reg, ebase_next;
    logic [4:0] ecnt_reg, ecnt_next;
    logic [4:0] etot_reg, etot_next;
    logic [15:0] eendc_reg, eendc_next;

    logic        ov_reg, ov_next;
    logic        o_kind_reg, o_kind_next;
    logic [7:0]  o_ridx_reg, o_ridx_next;
    logic [31:0] o_word_reg, o_word_next;
    logic [3:0]  o_st_reg, o_st_next;
    logic [15:0] o_endc_reg, o_endc_next;
    logic        o_inv_reg, o_inv_next;
    logic [7:0]  o_ist_reg, o_ist_next;
    logic [4:0]  o_icnt_reg, o_icnt_next;
    logic        o_last_reg, o_last_next;

    logic        out_free, in_acc, no_resp, byte_acc, first_byte;
    logic [4:0]  ww, we_eff;
    logic [1:0]  fail_inc;
    logic        inv;
    logic [7:0]  adv0, adv1;
    logic [8:0]  ws9, diff;
    logic        rd_en;
    logic [31:0] rd_data;

    function automatic logic [7:0] advance(input logic [7:0] ws, input logic [4:0] step,
                                           input logic [8:0] rc);
        logic [8:0] sum;
        sum = {1'b0, ws} + {4'd0, step};
        return (sum >= rc) ? 8'd0 : sum[7:0];
    endfunction

    hlrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign no_resp       = in_acc && s_axis_tuser[0];
    assign byte_acc      = in_acc && !s_axis_tuser[0];

    // words in the current window
    always_comb
    begin
        ws9  = {1'b0, ws_reg};
        diff = cfg.register_count - ws9;
        if (ws9 >= cfg.register_count)
            ww = 5'd0;
        else if ({4'd0, cfg.batch_count} < diff)
            ww = cfg.batch_count;
        else
            ww = diff[4:0];
        if (ww > 5'(BATCH_CAP))
            ww = 5'(BATCH_CAP);
    end

    assign we_eff   = first_byte ? ww : wexp_reg;
    assign fail_inc = (fail_reg == 2'd3) ? 2'd3 : fail_reg + 2'd1;
    assign inv      = (fail_inc == 2'd3);
    assign adv0     = advance(ws_reg, cfg.batch_count, cfg.register_count);
    assign adv1     = advance(adv0, cfg.batch_count, cfg.register_count);

    hlrc_frame_check u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_acc),
        .abort        (no_resp),
        .rx_byte      (s_axis_tdata),
        .frame_last   (s_axis_tlast),
        .section_kind (cfg.section_kind),
        .words_exp    (we_eff),
        .first_byte   (first_byte),
        .verdict      (verdict),
        .word_wr      (word_wr)
    );

    assign rd_en = (state_reg == S_EMIT_RD);

    hlrc_word_ram u_ram (
        .clk     (clk),
        .wr      (word_wr),
        .rd_en   (rd_en),
        .rd_addr (ecnt_reg[WADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        ws_next     = ws_reg;
        wexp_next   = wexp_reg;
        fail_next   = fail_reg;
        ebase_next  = ebase_reg;
        ecnt_next   = ecnt_reg;
        etot_next   = etot_reg;
        eendc_next  = eendc_reg;
        ov_next     = ov_reg && !m_axis_tready;
        o_kind_next = o_kind_reg;
        o_ridx_next = o_ridx_reg;
        o_word_next = o_word_reg;
        o_st_next   = o_st_reg;
        o_endc_next = o_endc_reg;
        o_inv_next  = o_inv_reg;
        o_ist_next  = o_ist_reg;
        o_icnt_next = o_icnt_reg;
        o_last_next = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (byte_acc && first_byte)
                    wexp_next = ww;
                if (no_resp)
                begin
                    wexp_next   = ww;
                    fail_next   = fail_inc;
                    ws_next     = inv ? adv0 : ws_reg;
                    ov_next     = 1'b1;
                    o_kind_next = 1'b1;
                    o_ridx_next = 8'd0;
                    o_word_next = 32'd0;
                    o_st_next   = ST_NO_RESP;
                    o_endc_next = 16'd0;
                    o_inv_next  = inv;
                    o_ist_next  = inv ? ws_reg : 8'd0;
                    o_icnt_next = inv ? ww : 5'd0;
                    o_last_next = 1'b1;
                end
                else if (verdict.done && (verdict.status != ST_OK))
                begin
                    fail_next   = fail_inc;
                    ws_next     = inv ? adv1 : adv0;
                    ov_next     = 1'b1;
                    o_kind_next = 1'b1;
                    o_ridx_next = 8'd0;
                    o_word_next = 32'd0;
                    o_st_next   = verdict.status;
                    o_endc_next = verdict.end_code;
                    o_inv_next  = inv;
                    o_ist_next  = inv ? adv0 : 8'd0;
                    o_icnt_next = inv ? we_eff : 5'd0;
                    o_last_next = 1'b1;
                end
                else if (verdict.done)
                begin
                    fail_next = 2'd0;
                    ws_next   = adv0;
                    if (we_eff == 5'd0)
                    begin
                        ov_next     = 1'b1;
                        o_kind_next = 1'b1;
                        o_ridx_next = 8'd0;
                        o_word_next = 32'd0;
                        o_st_next   = ST_OK;
                        o_endc_next = verdict.end_code;
                        o_inv_next  = 1'b0;
                        o_ist_next  = 8'd0;
                        o_icnt_next = 5'd0;
                        o_last_next = 1'b1;
                    end
                    else
                    begin
                        ebase_next = ws_reg;
                        ecnt_next  = 5'd0;
                        etot_next  = we_eff;
                        eendc_next = verdict.end_code;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_kind_next = 1'b0;
                    o_ridx_next = ebase_reg + {3'd0, ecnt_reg};
                    o_word_next = rd_data;
                    o_st_next   = ST_OK;
                    o_endc_next = eendc_reg;
                    o_inv_next  = 1'b0;
                    o_ist_next  = 8'd0;
                    o_icnt_next = 5'd0;
                    o_last_next = (ecnt_reg + 5'd1 == etot_reg);
                    ecnt_next   = ecnt_reg + 5'd1;
                    state_next  = (ecnt_reg + 5'd1 == etot_reg) ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ws_reg    <= 8'd0;
            wexp_reg  <= 5'd0;
            fail_reg  <= 2'd0;
            ecnt_reg  <= 5'd0;
            etot_reg  <= 5'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ws_reg    <= ws_next;
            wexp_reg  <= wexp_next;
            fail_reg  <= fail_next;
            ecnt_reg  <= ecnt_next;
            etot_reg  <= etot_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ebase_reg  <= ebase_next;
        eendc_reg  <= eendc_next;
        o_kind_reg <= o_kind_next;
        o_ridx_reg <= o_ridx_next;
        o_word_reg <= o_word_next;
        o_st_reg   <= o_st_next;
        o_endc_reg <= o_endc_next;
        o_inv_reg  <= o_inv_next;
        o_ist_reg  <= o_ist_next;
        o_icnt_reg <= o_icnt_next;
        o_last_reg <= o_last_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {6'd0, o_icnt_reg, o_ist_reg, o_inv_reg, o_endc_reg,
                            o_st_reg, o_word_reg, o_ridx_reg};

endmodule

### rtl/hlrc_checker.sv
// port-level assertions for the response checker and their binding
module hlrc_checker
    import hlrc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // invalidation only rides on a status transfer
    a_inv_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[60] |-> m_axis_tuser[0])
        else $error("invalidate on a data transfer");

    // data words come only from good frames
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[43:40] == ST_OK)
        else $error("data transfer with bad status");

    // a status transfer is always the final one of its event
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("status transfer without last");

    // invalidation range never exceeds one batch
    a_inv_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[73:69] <= 5'd30)
        else $error("invalidate count out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

endmodule

bind host_link_response_checker hlrc_checker u_hlrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_host_link_response_checker.sv
// testbench for host_link_response_checker: framed byte stimulus, model-based result check
`timescale 1ns / 1ps

module tb_host_link_response_checker;
    import hlrc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  register_index;
        logic [31:0] word_chars;
        logic [3:0]  status;
        logic [15:0] end_code;
        logic        invalidate;
        logic [7:0]  invalidate_start;
        logic [4:0]  invalidate_count;
        logic        last;
    } link_result_t;

    localparam int RANDOM_ITEMS = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // rx_byte
    logic [0:0]  s_axis_tuser = '0;    // req_type
    logic        s_axis_tlast = 1'b0;  // frame_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // register_index, word_chars, status, end_code, invalidate, invalidate_start,
    // invalidate_count, zero pad
    logic [79:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;         // result_kind
    logic        m_axis_tlast;         // last

    host_link_response_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // frame checker state as predicted
    logic [1:0]  cfg_section = SEC_DM;
    int          cfg_registers = 0;
    int          cfg_batch = BATCH_DEFAULT;
    int          win_start = 0;
    int          words_due = 0;
    int          fail_run = 0;
    int          byte_pos = 0;
    logic [7:0]  fcs_acc = '0;
    logic [31:0] last_four = '0;
    logic [31:0] echo_bytes = '0;
    bit          at_missing = 1'b0;
    logic [31:0] staged [MAX_BATCH];

    link_result_t awaited[$];
    logic [7:0]   frame_bytes[$];
    int           mismatches = 0;
    int           items_sent = 0;
    bit           quiet = 1'b0;
    int           stall_left = 0;

    function automatic logic [7:0] ascii_hex(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] echo_for(input logic [1:0] sec);
        case (sec)
            SEC_DM:  return 8'h44;
            SEC_HR:  return 8'h48;
            SEC_IO:  return 8'h52;
            default: return 8'h00;
        endcase
    endfunction

    function automatic int polled_window_size();
        int n;
        if (win_start >= cfg_registers)
            return 0;
        n = cfg_registers - win_start;
        if (cfg_batch < n)
            n = cfg_batch;
        if (n > BATCH_CAP)
            n = BATCH_CAP;
        return n;
    endfunction

    function automatic void step_window();
        win_start += cfg_batch;
        if (win_start >= cfg_registers)
            win_start = 0;
    endfunction

    function automatic void drop_frame();
        byte_pos = 0;
        fcs_acc = '0;
        last_four = '0;
        at_missing = 1'b0;
        echo_bytes = '0;
    endfunction

    function automatic void queue_result(input logic kind, input int idx,
                                         input logic [31:0] chars, input logic [3:0] st,
                                         input logic [15:0] endc, input logic inv,
                                         input int ist, input int icnt, input logic lst);
        link_result_t r;
        r.kind = kind;
        r.register_index = 8'(idx);
        r.word_chars = chars;
        r.status = st;
        r.end_code = endc;
        r.invalidate = inv;
        r.invalidate_start = 8'(ist);
        r.invalidate_count = 5'(icnt);
        r.last = lst;
        awaited.push_back(r);
    endfunction

    function automatic void report_failure(input logic [3:0] st, input logic [15:0] endc);
        logic inv;
        int   ist;
        int   icnt;
        inv = 1'b0;
        ist = 0;
        icnt = 0;
        if (fail_run < 3)
            fail_run++;
        if (fail_run >= 3)
        begin
            inv = 1'b1;
            ist = win_start;
            icnt = words_due;
            step_window();
        end
        queue_result(1'b1, 0, '0, st, endc, inv, ist, icnt, 1'b1);
    endfunction

    function automatic void compute_link_results(input logic req, input logic [7:0] b,
                                                 input logic lst);
        int          p;
        int          idx;
        logic [3:0]  st;
        logic [15:0] endc;
        logic [7:0]  fcs;
        if (req)
        begin
            drop_frame();
            words_due = polled_window_size();
            report_failure(ST_NO_RESP, '0);
            return;
        end
        p = byte_pos;
        if (p == 0)
        begin
            words_due = polled_window_size();
            if (b != CH_AT)
                at_missing = 1'b1;
        end
        if (p >= 3 && p <= 6)
            echo_bytes |= 32'(b) << ((6 - p) * 8);
        if (p >= 7)
        begin
            idx = (p - 7) / 4;
            if (idx < MAX_BATCH)
                staged[idx] = {staged[idx][23:0], b};
        end
        fcs_acc ^= b;
        last_four = {last_four[23:0], b};
        if (byte_pos < 255)
            byte_pos++;
        if (!lst)
            return;

        endc = echo_bytes[15:0];
        fcs = fcs_acc ^ last_four[7:0] ^ last_four[15:8] ^ last_four[23:16]
            ^ last_four[31:24];
        if (at_missing)
            st = ST_NO_AT;
        else if (endc != END_OK)
            st = ST_END_CODE;
        else if (byte_pos != words_due * 4 + int'(FRAME_OVH))
            st = ST_LENGTH;
        else if (last_four[7:0] != CH_CR)
            st = ST_NO_CR;
        else if (last_four[15:8] != CH_STAR)
            st = ST_NO_STAR;
        else if (cfg_section > SEC_IO || echo_bytes[31:24] != CH_R
                 || echo_bytes[23:16] != echo_for(cfg_section))
            st = ST_COMMAND;
        else if (last_four[31:24] != ascii_hex(fcs[7:4])
                 || last_four[23:16] != ascii_hex(fcs[3:0]))
            st = ST_FCS;
        else
            st = ST_OK;
        drop_frame();

        if (st != ST_OK)
        begin
            step_window();
            report_failure(st, endc);
            return;
        end
        fail_run = 0;
        if (words_due == 0)
            queue_result(1'b1, 0, '0, ST_OK, endc, 1'b0, 0, 0, 1'b1);
        for (int k = 0; k < words_due && k < MAX_BATCH; k++)
            queue_result(1'b0, win_start + k, staged[k], ST_OK, endc, 1'b0, 0, 0,
                         k + 1 == words_due);
        step_window();
    endfunction

    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left = idle_gap();
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        link_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited.size() == 0)
            begin
                $error("output transfer with no result pending");
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                compare_field("result_kind", want.kind, m_axis_tuser[0]);
                compare_field("register_index", want.register_index, m_axis_tdata[7:0]);
                compare_field("word_chars", want.word_chars, m_axis_tdata[39:8]);
                compare_field("status", want.status, m_axis_tdata[43:40]);
                compare_field("end_code", want.end_code, m_axis_tdata[59:44]);
                compare_field("invalidate", want.invalidate, m_axis_tdata[60]);
                compare_field("invalidate_start", want.invalidate_start,
                              m_axis_tdata[68:61]);
                compare_field("invalidate_count", want.invalidate_count,
                              m_axis_tdata[73:69]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end
    end

    task automatic send_item(input logic req, input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        compute_link_results(req, b, lst);
        items_sent++;
    endtask

    task automatic send_bytes(input int count, input bit close);
        for (int i = 0; i < count; i++)
            send_item(1'b0, frame_bytes[i], close && i == count - 1);
    endtask

    task automatic send_frame();
        send_bytes(frame_bytes.size(), 1'b1);
    endtask

    task automatic send_no_response();
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // pause until every result is out, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [1:0] sec, input int count, input int batch);
        write_reg(REG_SECTION, 32'(sec));
        write_reg(REG_COUNT, 32'(count & 9'h1FF));
        write_reg(REG_BATCH, 32'(batch & 5'h1F));
        cfg_section = sec;
        cfg_registers = (count & 9'h1FF) > MAX_REGISTERS ? MAX_REGISTERS : count & 9'h1FF;
        cfg_batch = (batch & 5'h1F) > int'(BATCH_LIMIT) ? int'(BATCH_DEFAULT)
                                                         : batch & 5'h1F;
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == avoid) ? ~b : b;
    endfunction

    // well-formed response for the current section; fill < 0 gives random data
    task automatic build_good_frame(input int n, input int fill);
        logic [7:0] sum;
        frame_bytes.delete();
        frame_bytes.push_back(CH_AT);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(CH_R);
        if (cfg_section > SEC_IO)
            frame_bytes.push_back(echo_for(2'($urandom_range(0, 2))));
        else
            frame_bytes.push_back(echo_for(cfg_section));
        frame_bytes.push_back(END_OK[15:8]);
        frame_bytes.push_back(END_OK[7:0]);
        repeat (4 * n)
            frame_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
        sum = '0;
        foreach (frame_bytes[i])
            sum ^= frame_bytes[i];
        frame_bytes.push_back(ascii_hex(sum[7:4]));
        frame_bytes.push_back(ascii_hex(sum[3:0]));
        frame_bytes.push_back(CH_STAR);
        frame_bytes.push_back(CH_CR);
    endtask

    task automatic damage_frame(input logic [3:0] st);
        int sz;
        int idx;
        sz = frame_bytes.size();
        case (st)
            ST_NO_AT:
                frame_bytes[0] = other_than(CH_AT);
            ST_END_CODE:
            begin
                idx = 5 + $urandom_range(0, 1);
                frame_bytes[idx] = other_than(8'h30);
            end
            ST_LENGTH:
                if ($urandom_range(0, 1) == 0)
                    frame_bytes.insert(7, 8'($urandom_range(0, 255)));
                else
                begin
                    idx = $urandom_range(7, sz - 1);
                    while (frame_bytes.size() > idx)
                        void'(frame_bytes.pop_back());
                end
            ST_NO_CR:
                frame_bytes[sz - 1] = other_than(CH_CR);
            ST_NO_STAR:
                frame_bytes[sz - 2] = other_than(CH_STAR);
            ST_COMMAND:
            begin
                idx = 3 + $urandom_range(0, 1);
                frame_bytes[idx] = other_than(frame_bytes[idx]);
            end
            ST_FCS:
            begin
                idx = sz - 4 + $urandom_range(0, 1);
                if (frame_bytes[idx] >= 8'h41 && $urandom_range(0, 1) == 0)
                    frame_bytes[idx] = frame_bytes[idx] | 8'h20;
                else
                    frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            default:
                ;
        endcase
    endtask

    task automatic test_empty_frame_after_reset();
        build_good_frame(polled_window_size(), -1);
        send_frame();
    endtask

    task automatic test_missing_responses();
        repeat (3) send_no_response();
        build_good_frame(polled_window_size(), -1);
        send_bytes(5, 1'b0);
        send_no_response();
    endtask

    task automatic test_short_frames();
        send_item(1'b0, CH_AT, 1'b1);
        send_item(1'b0, 8'hFF, 1'b1);
    endtask

    task automatic test_each_status();
        settle();
        set_config(SEC_HR, 0, 30);
        for (logic [3:0] st = ST_NO_AT; st <= ST_FCS; st++)
        begin
            build_good_frame(polled_window_size(), -1);
            damage_frame(st);
            send_frame();
        end
        for (int sec = 0; sec < 4; sec++)
        begin
            settle();
            set_config(2'(sec), 0, 30);
            build_good_frame(polled_window_size(), -1);
            send_frame();
        end
    endtask

    // window at zero with no failures pending
    task automatic rewind_window(input logic [1:0] sec, input int batch);
        settle();
        set_config(sec, 0, batch);
        send_item(1'b0, 8'h00, 1'b1);
        build_good_frame(0, -1);
        send_frame();
        settle();
    endtask

    task automatic test_register_range_edges();
        int tries;
        rewind_window(SEC_IO, 30);
        set_config(SEC_IO, 511, 30);
        tries = 0;
        while (win_start != 240 && tries < 12)
        begin
            send_item(1'b0, 8'h00, 1'b1);
            tries++;
        end
        build_good_frame(polled_window_size(), 8'hFF);
        send_frame();
    endtask

    task automatic test_invalid_batch();
        rewind_window(SEC_DM, 31);
        set_config(SEC_DM, 26, 31);
        send_item(1'b0, 8'h00, 1'b1);
        build_good_frame(polled_window_size(), 8'h00);
        send_frame();
    endtask

    task automatic pick_random_config();
        int sec;
        int count;
        int batch;
        int r;
        sec = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        r = $urandom_range(0, 9);
        if (r < 5)
            count = $urandom_range(1, 40);
        else if (r < 6)
            count = 0;
        else if (r < 8)
            count = $urandom_range(0, 511);
        else
            count = $urandom_range(256, 511);
        r = $urandom_range(0, 9);
        if (r < 7)
            batch = $urandom_range(0, 8);
        else if (r < 9)
            batch = $urandom_range(9, 31);
        else
            batch = $urandom_range(30, 31);
        settle();
        set_config(2'(sec), count, batch);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int next_config;
        int pick;
        int cut;
        stop_at = items_sent + RANDOM_ITEMS;
        next_config = items_sent;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_config)
            begin
                pick_random_config();
                next_config = items_sent + $urandom_range(40, 90);
            end
            quiet = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            build_good_frame(polled_window_size(), -1);
            if (pick < 60)
                send_frame();
            else if (pick < 80)
            begin
                damage_frame(4'($urandom_range(ST_NO_AT, ST_FCS)));
                send_frame();
            end
            else if (pick < 87)
                send_no_response();
            else if (pick < 93)
            begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                send_bytes(cut, 1'b0);
                send_no_response();
            end
            else
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 12))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                send_frame();
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        foreach (staged[i])
            staged[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_frame_after_reset();
        test_missing_responses();
        test_short_frames();
        test_each_status();
        test_register_range_edges();
        test_invalid_batch();
        test_random_traffic();
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
